// ===== rtl/rav_pkg.sv =====
// rav_pkg: shared types and constants for rank_assign_by_value
// no dependencies; imported by every module of the block except the generic rav_ram
`default_nettype none

package rav_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 32;
  localparam int RANK_W    = 7;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      final_item;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              run_end;
    logic              overflowed;
  } out_item_t;

  // one loaded set handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflowed;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [VALUE_W-1:0] data;
  } ram_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CAPTURE,
    BK_SCAN,
    BK_PUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/rank_assign_by_value.sv =====
// rank_assign_by_value: top level, loads a set of signed values and emits their ranks
// depends on rav_pkg, rav_ram, rav_front, rav_job_queue, rav_back
//
//   channel  direction  handshake           payload
//   in       input      in_valid_i/stall_o  sample_value, final_item
//   out      output     out_valid_o/stall_i rank, run_end, overflowed
//
// loading takes one value per cycle while the input is not stalled; values past the store capacity are dropped
// ranking a set of n values takes each result through capture, n compares and output,
// one result at a time, bound by the single ram read port
// the input is stalled from the final request until the last rank is registered
// reset is asynchronous and clears control state only; the value ram is not cleared
`default_nettype none

module rank_assign_by_value (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire rav_pkg::in_item_t in_data_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output rav_pkg::out_item_t     out_data_o,
  input  wire logic              out_stall_i
);

  import rav_pkg::*;

  ram_wr_t            ram_wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               push_valid, push_stall;
  job_t               push_job;
  logic               pop_valid, pop_stall;
  job_t               pop_job;
  logic               done;

  rav_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_wr.en),
    .waddr_i(ram_wr.addr),
    .wdata_i(ram_wr.data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  rav_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .ram_wr_o   (ram_wr),
    .job_valid_o(push_valid),
    .job_o      (push_job),
    .job_stall_i(push_stall),
    .done_i     (done)
  );

  rav_job_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_i      (push_job),
    .push_stall_o(push_stall),
    .pop_valid_o (pop_valid),
    .pop_o       (pop_job),
    .pop_stall_i (pop_stall)
  );

  rav_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_i      (pop_job),
    .job_stall_o(pop_stall),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .done_o     (done),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire

// ===== rtl/rav_ram.sv =====
// rav_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rav_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rav_front.sv =====
// rav_front: accepts values, writes them to the value ram in load order
// depends on rav_pkg; hands each finished set to the job queue
`default_nettype none

module rav_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire rav_pkg::in_item_t in_data_i,
  output logic                  in_stall_o,
  output rav_pkg::ram_wr_t      ram_wr_o,
  output logic                  job_valid_o,
  output rav_pkg::job_t         job_o,
  input  wire logic             job_stall_i,
  input  wire logic             done_i
);

  import rav_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             busy_q, busy_d;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_inc;

  // a set being ranked owns the ram, so new requests wait
  assign in_stall_o = busy_q | job_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign room       = count_q < CNT_W'(MAX_ITEMS);
  assign count_inc  = count_q + CNT_W'(1);

  assign ram_wr_o.en   = accept & room;
  assign ram_wr_o.addr = count_q[IDX_W-1:0];
  assign ram_wr_o.data = in_data_i.sample_value;

  assign job_valid_o      = accept & in_data_i.final_item;
  assign job_o.count      = room ? count_inc : count_q;
  assign job_o.overflowed = ovf_q | ~room;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    if (accept) begin
      if (in_data_i.final_item) begin
        count_d = '0;
        ovf_d   = 1'b0;
        busy_d  = 1'b1;
      end else begin
        count_d = room ? count_inc : count_q;
        ovf_d   = ovf_q | ~room;
      end
    end
    if (done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rav_job_queue.sv =====
// rav_job_queue: two-entry fifo of loaded sets between front and back
// depends on rav_pkg
`default_nettype none

module rav_job_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  input  wire rav_pkg::job_t push_i,
  output logic               push_stall_o,
  output logic               pop_valid_o,
  output rav_pkg::job_t      pop_o,
  input  wire logic          pop_stall_i
);

  import rav_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_stall_o = fill_q == 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign pop_o        = entry_q[rd_ptr_q];
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_valid_o & ~pop_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rav_back.sv =====
// rav_back: ranks each stored value by scanning the value ram once per entry
// depends on rav_pkg; reads the ram through its single registered read port
`default_nettype none

module rav_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  input  wire rav_pkg::job_t                 job_i,
  output logic                               job_stall_o,
  output logic [rav_pkg::IDX_W-1:0]          rd_addr_o,
  input  wire logic [rav_pkg::VALUE_W-1:0]   rd_data_i,
  output logic                               done_o,
  output logic                               out_valid_o,
  output rav_pkg::out_item_t                 out_data_o,
  input  wire logic                          out_stall_i
);

  import rav_pkg::*;

  back_state_e               state_q, state_d;
  job_t                      job_q, job_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic [IDX_W-1:0]          cmp_q, cmp_d;
  logic signed [VALUE_W-1:0] v_q, v_d;
  logic [CNT_W-1:0]          rank_q, rank_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic hit;
  logic last_cmp;
  logic last_pos;
  logic out_free;

  // smaller values count, and equal ones loaded later
  assign hit = ($signed(rd_data_i) < v_q) || ((rd_data_i == v_q) && (cmp_q > pos_q));
  assign last_cmp = (CNT_W'(cmp_q) + CNT_W'(1)) == job_q.count;
  assign last_pos = (CNT_W'(pos_q) + CNT_W'(1)) == job_q.count;
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    pos_d       = pos_q;
    cmp_d       = cmp_q;
    v_d         = v_q;
    rank_d      = rank_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    job_stall_o = 1'b1;
    rd_addr_o   = '0;
    done_o      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        job_stall_o = 1'b0;
        if (job_valid_i) begin
          job_d   = job_i;
          pos_d   = '0;
          state_d = BK_CAPTURE;
        end
      end
      BK_CAPTURE: begin
        v_d     = rd_data_i;
        cmp_d   = '0;
        rank_d  = CNT_W'(1);
        state_d = BK_SCAN;
      end
      BK_SCAN: begin
        rank_d = rank_q + CNT_W'(hit);
        if (last_cmp) begin
          state_d = BK_PUT;
        end else begin
          rd_addr_o = cmp_q + IDX_W'(1);
          cmp_d     = cmp_q + IDX_W'(1);
        end
      end
      BK_PUT: begin
        // prefetch the next entry's value while the result waits
        rd_addr_o = pos_q + IDX_W'(1);
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.rank       = RANK_W'(rank_q);
          out_d.run_end    = last_pos;
          out_d.overflowed = job_q.overflowed;
          if (last_pos) begin
            done_o  = 1'b1;
            state_d = BK_IDLE;
          end else begin
            pos_d   = pos_q + IDX_W'(1);
            state_d = BK_CAPTURE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    pos_q  <= pos_d;
    cmp_q  <= cmp_d;
    v_q    <= v_d;
    rank_q <= rank_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_rank_assign_by_value.sv =====
// tb_rank_assign_by_value: self-checking regression for rank_assign_by_value
// loads sets of signed values, predicts ranks in load order, compares every result
// depends on rav_pkg and the rank_assign_by_value rtl
`timescale 1ns / 100ps

module tb_rank_assign_by_value;
  import rav_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int SETTLE_CYCLES = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_data_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i = 1'b0;

  // sender gap and receiver stall chances, in percent per cycle
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // predictor state: values of the set being loaded
  logic signed [VALUE_W-1:0] held_values [MAX_ITEMS];
  int unsigned               held_count = 0;
  logic                      dropped_flag = 1'b0;

  out_item_t   pending_ranks [$];
  bit          mismatch_seen = 1'b0;
  int unsigned cycle_count = 0;

  rank_assign_by_value dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("rank_assign_by_value regression: fail");
      $finish;
    end
  end

  // 1 + smaller values + later equal values, masked to the rank width
  function automatic logic [RANK_W-1:0] rank_within_set(input int unsigned pos);
    int unsigned r;
    r = 1;
    for (int unsigned j = 0; j < held_count; j++) begin
      if (held_values[j] < held_values[pos] ||
          (held_values[j] == held_values[pos] && j > pos)) r++;
    end
    return r[RANK_W-1:0];
  endfunction

  function automatic void load_value(input logic signed [VALUE_W-1:0] v, input logic fin);
    out_item_t ranked;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (fin) begin
      for (int unsigned k = 0; k < held_count; k++) begin
        ranked.rank       = rank_within_set(k);
        ranked.run_end    = (k + 1 == held_count);
        ranked.overflowed = dropped_flag;
        pending_ranks.push_back(ranked);
      end
      held_count   = 0;
      dropped_flag = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin : check_ranks
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rank %0d run_end %0b ovf %0b",
                 $time, out_data_o.rank, out_data_o.run_end, out_data_o.overflowed);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_ranks.pop_front();
        if (out_data_o.rank !== want.rank) begin
          $display("%0t: rank mismatch: expected %0d, actual %0d",
                   $time, want.rank, out_data_o.rank);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.run_end !== want.run_end) begin
          $display("%0t: run_end mismatch: expected %0b, actual %0b",
                   $time, want.run_end, out_data_o.run_end);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.overflowed !== want.overflowed) begin
          $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                   $time, want.overflowed, out_data_o.overflowed);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // one request, held until the block takes it
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.sample_value <= v;
    in_data_i.final_item   <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    load_value(v, fin);
  endtask

  task automatic drain_ranks();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ranks.size() != 0);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0:       v = $signed(VALUE_W'($urandom_range(8))) - 4;
      1:       v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                     : 32'sh8000_0000 + $urandom_range(3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_single_value();
    send_value(32'sh8000_0000, 1'b1);
    send_value(32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh0000_0000, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sh7FFF_FFFE, 1'b1);
  endtask

  // equal values: the earlier one ranks higher
  task automatic test_equal_values();
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd5, 1'b1);
    send_value(32'sd0, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(32'sd0, 1'b1);
  endtask

  // store filled, then the final request dropped as overflow, then a clean set
  task automatic test_store_full();
    for (int i = 0; i < MAX_ITEMS + 1; i++) send_value(pick_value(), i == MAX_ITEMS);
    send_value(32'sd3, 1'b0);
    send_value(-32'sd3, 1'b1);
  endtask

  task automatic test_random_sets(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_value();
    test_extreme_values();
    test_equal_values();
    drain_ranks();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    test_store_full();
    drain_ranks();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sets(7);
    send_idle_pct  = 60;
    test_random_sets(7);
    drain_ranks();
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    test_random_sets(7);
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    test_random_sets(7);

    drain_ranks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("rank_assign_by_value regression: pass");
    end else begin
      $display("rank_assign_by_value regression: fail");
    end
    $finish;
  end

endmodule
